@@ hdl/assert_macros.svh @@
// Assertion helpers used by the arithmetic unit RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside of reset.
`define GFAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define GFAU_ASSERT_IMPL(lbl, ante, cons, msg) \
  `GFAU_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define GFAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  `GFAU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ hdl/gfau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit package
// Field constants, operation codes and the table port structures.
// ----------------------------------------------------------------------------
package gfau_pkg;

  localparam int unsigned GfWidth   = 8;
  localparam int unsigned ElemCount = 1 << GfWidth;
  localparam int unsigned Order     = ElemCount - 1;

  typedef logic [GfWidth-1:0] gf_elem_t;

  // Operation codes carried in the kind field.
  typedef enum logic [2:0] {
    KindAdd = 3'd0,
    KindSub = 3'd1,
    KindMul = 3'd2,
    KindDiv = 3'd3,
    KindPow = 3'd4
  } gfau_kind_e;

  // Table builder states.
  typedef enum logic {
    BuildRun  = 1'b0,
    BuildFill = 1'b1
  } gfau_build_e;

  // Register indexes of the configuration port.
  localparam logic RegPoly = 1'b0;

  // Read requests from the datapath to the tables.
  typedef struct packed {
    logic     log_en;
    gf_elem_t log_addr_a;
    gf_elem_t log_addr_b;
    logic     exp_en;
    gf_elem_t exp_addr;
  } gfau_rd_req_t;

  // Registered read data and builder status.
  typedef struct packed {
    logic     busy;
    gf_elem_t log_a;
    gf_elem_t log_b;
    gf_elem_t exp_data;
  } gfau_rd_rsp_t;

endpackage

@@ hdl/gfau_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface gfau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  operand_a;
  logic [7:0]  operand_b;
  logic [15:0] exponent;

  modport source (output valid, kind, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, exponent, output ready);
endinterface

interface gfau_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic       divide_by_zero;

  modport source (output valid, result, divide_by_zero, input ready);
  modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

@@ hdl/gfau_tables.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^8) log and exp tables
// Builds both tables from the polynomial by stepping through powers of x,
// one power per cycle, and serves two log reads and one exp read per cycle.
// ----------------------------------------------------------------------------
module gfau_tables
  import gfau_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         rebuild_i,
  input  logic [8:0]   poly_i,
  input  gfau_rd_req_t req_i,
  output gfau_rd_rsp_t rsp_o
);

  gf_elem_t    log_mem [ElemCount];
  gf_elem_t    exp_mem [ElemCount];
  logic [ElemCount-1:0] vld_q;

  gfau_build_e state_q, state_d;
  gf_elem_t    step_q, step_d;
  gf_elem_t    pow_q, pow_d;
  logic        fill;

  gf_elem_t    log_a_q, log_b_q, exp_q;
  logic        va_q, vb_q;

  // Builder sequencer: one power of x per cycle.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    pow_d   = pow_q;
    fill    = 1'b0;
    case (state_q)
      BuildFill: begin
        fill   = 1'b1;
        step_d = step_q + 1'b1;
        pow_d  = {pow_q[GfWidth-2:0], 1'b0} ^ (pow_q[GfWidth-1] ? poly_i[GfWidth-1:0] : '0);
        if (step_q == gf_elem_t'(Order - 1)) begin
          state_d = BuildRun;
        end
      end
      default: begin
      end
    endcase
    if (rebuild_i) begin
      state_d = BuildFill;
      step_d  = '0;
      pow_d   = gf_elem_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BuildFill;
      step_q  <= '0;
      pow_q   <= gf_elem_t'(1);
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pow_q   <= pow_d;
      if (rebuild_i) begin
        vld_q <= '0;
      end else if (fill) begin
        vld_q[pow_q] <= 1'b1;
      end
    end
  end

  // Table writes during the build; later powers overwrite earlier log entries.
  always_ff @(posedge clk_i) begin
    if (fill) begin
      log_mem[pow_q]  <= step_q;
      exp_mem[step_q] <= pow_q;
    end
  end

  // Registered reads, held while the owning stage stalls.
  always_ff @(posedge clk_i) begin
    if (req_i.log_en) begin
      log_a_q <= log_mem[req_i.log_addr_a];
      log_b_q <= log_mem[req_i.log_addr_b];
      va_q    <= vld_q[req_i.log_addr_a];
      vb_q    <= vld_q[req_i.log_addr_b];
    end
    if (req_i.exp_en) begin
      exp_q <= exp_mem[req_i.exp_addr];
    end
  end

  // An element never reached by the build reads as log 0.
  assign rsp_o.busy     = (state_q == BuildFill);
  assign rsp_o.log_a    = va_q ? log_a_q : '0;
  assign rsp_o.log_b    = vb_q ? log_b_q : '0;
  assign rsp_o.exp_data = exp_q;

endmodule

@@ hdl/gf256_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit
// Add, subtract, multiply, divide and power over GF(2^8) with log/exp tables.
// ----------------------------------------------------------------------------
// Four-stage pipeline accepting one item per cycle while the output is not
// stalled and no table rebuild is running. Stage one reads the log table and
// reduces the exponent modulo 255, stage two forms the log sum or difference
// and the log product, stage three reduces the product and reads the exp
// table, stage four holds the result. After reset and after every write of
// the polynomial register the tables are rebuilt, during which no item is
// accepted.
`include "assert_macros.svh"

module gf256_arithmetic_unit
  import gfau_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  gfau_in_if.sink       src_i,
  gfau_out_if.source    res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [8:0]   poly_q;
  logic         rebuild;
  gfau_rd_req_t req;
  gfau_rd_rsp_t rsp;

  // Configuration port.
  assign pready  = 1'b1;
  assign rebuild = psel && penable && pwrite && (paddr[2] == RegPoly);
  assign prdata  = (paddr[2] == RegPoly) ? {23'd0, poly_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= 9'd285;
    end else if (rebuild) begin
      poly_q <= pwdata[8:0];
    end
  end

  gfau_tables u_tables (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rebuild_i (rebuild),
    .poly_i    (poly_q),
    .req_i     (req),
    .rsp_o     (rsp)
  );

  // Stage enables.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || res_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign src_i.ready = en1 && !rsp.busy;

  // Stage one: capture the item, reduce the exponent modulo 255.
  logic [2:0]  kind1_q;
  gf_elem_t    a1_q, b1_q, em1_q;
  logic        ez1_q;
  logic [8:0]  es, es2;

  assign es  = {1'b0, src_i.exponent[7:0]} + {1'b0, src_i.exponent[15:8]};
  assign es2 = {1'b0, es[7:0]} + {8'd0, es[8]};

  assign req.log_en     = en1;
  assign req.log_addr_a = src_i.operand_a;
  assign req.log_addr_b = src_i.operand_b;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      kind1_q <= src_i.kind;
      a1_q    <= src_i.operand_a;
      b1_q    <= src_i.operand_b;
      ez1_q   <= (src_i.exponent == 16'd0);
      em1_q   <= (es2 == 9'(Order)) ? '0 : es2[7:0];
    end
  end

  // Stage two: XOR for add and subtract, log index for multiply and divide, log product for power.
  logic       pow2_q, use_exp2_q, dz2_q;
  gf_elem_t   idx2_q, const2_q;
  logic [15:0] prod2_q;
  logic [8:0] lsum, ldif;
  gf_elem_t   idx2_d, const2_d;
  logic       use_exp2_d, dz2_d;

  assign lsum = {1'b0, rsp.log_a} + {1'b0, rsp.log_b};
  assign ldif = {1'b0, rsp.log_a} + 9'(Order) - {1'b0, rsp.log_b};

  always_comb begin
    idx2_d     = '0;
    const2_d   = '0;
    use_exp2_d = 1'b0;
    dz2_d      = 1'b0;
    case (kind1_q)
      KindAdd, KindSub: begin
        const2_d = a1_q ^ b1_q;
      end
      KindMul: begin
        use_exp2_d = (a1_q != '0) && (b1_q != '0);
        idx2_d     = (lsum >= 9'(Order)) ? 8'(lsum - 9'(Order)) : lsum[7:0];
      end
      KindDiv: begin
        dz2_d      = (b1_q == '0);
        use_exp2_d = (a1_q != '0) && (b1_q != '0);
        idx2_d     = (ldif >= 9'(Order)) ? 8'(ldif - 9'(Order)) : ldif[7:0];
      end
      KindPow: begin
        use_exp2_d = (a1_q != '0);
        const2_d   = gf_elem_t'(ez1_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pow2_q     <= (kind1_q == KindPow);
      use_exp2_q <= use_exp2_d;
      dz2_q      <= dz2_d;
      idx2_q     <= idx2_d;
      const2_q   <= const2_d;
      prod2_q    <= 16'(rsp.log_a) * 16'(em1_q);
    end
  end

  // Stage three: reduce the log product and read the exp table.
  logic      use_exp3_q, dz3_q;
  gf_elem_t  const3_q;
  logic [8:0] ps, ps2;
  gf_elem_t  pm;

  assign ps  = {1'b0, prod2_q[7:0]} + {1'b0, prod2_q[15:8]};
  assign ps2 = {1'b0, ps[7:0]} + {8'd0, ps[8]};
  assign pm  = (ps2 == 9'(Order)) ? '0 : ps2[7:0];

  assign req.exp_en   = en3;
  assign req.exp_addr = pow2_q ? pm : idx2_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      use_exp3_q <= use_exp2_q;
      dz3_q      <= dz2_q;
      const3_q   <= const2_q;
    end
  end

  // Stage four: result register.
  gf_elem_t res4_q;
  logic     dz4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      res4_q <= use_exp3_q ? rsp.exp_data : const3_q;
      dz4_q  <= dz3_q;
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= src_i.valid && src_i.ready;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign res_o.valid          = v4_q;
  assign res_o.result         = res4_q;
  assign res_o.divide_by_zero = dz4_q;

  // Checks on the table builder and the result.
  `GFAU_ASSERT_IMPL(a_no_accept_busy, src_i.ready, !rsp.busy, "ready while tables build")
  `GFAU_ASSERT_IMPL(a_dz_zero, res_o.valid && res_o.divide_by_zero, res_o.result == 8'd0, "dz nonzero")
  `GFAU_ASSERT_NEXT(a_rebuild_busy, rebuild, rsp.busy, "write did not start a rebuild")

endmodule
